>>> rtl/ring_byte_fifo_allocator_macros.svh
// assertion macros for the ring byte allocator
`ifndef RING_BYTE_FIFO_ALLOCATOR_MACROS_SVH
`define RING_BYTE_FIFO_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define RBFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbfa check failed");

// next-cycle implication, checked outside reset
`define RBFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbfa check failed");

`endif

>>> rtl/rbfa_pkg.sv
// shared types, constants and size helper for the ring byte allocator
package rbfa_pkg;

  localparam int LINE_BYTES       = 64;
  localparam int LINE_LOG2        = $clog2(LINE_BYTES);
  localparam int MAX_BUFFER_BYTES = 1048576;
  localparam int HEAD_LIMIT       = 1048576;
  localparam int SIZE_CAP         = (MAX_BUFFER_BYTES < HEAD_LIMIT) ?
                                    MAX_BUFFER_BYTES : HEAD_LIMIT;
  localparam int RESET_BUFFER     = 65536;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_UNSPLIT = 2'd1,
    KIND_FREE    = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  fragment_count;
    logic [19:0] first_offset;
    logic [20:0] first_length;
    logic        second_offset;
    logic [20:0] second_length;
    logic [5:0]  align_padding;
    logic [20:0] end_padding;
    logic        fits;
    logic        no_space_error;
    logic [20:0] free_bytes;
  } result_t;

  // cap, round down to the line size, floor at one line
  function automatic logic [20:0] eff_size(input logic [20:0] req);
    logic [20:0] s;
    s = req;
    if (s > 21'(SIZE_CAP)) s = 21'(SIZE_CAP);
    s = (s >> LINE_LOG2) << LINE_LOG2;
    if (s < 21'(LINE_BYTES)) s = 21'(LINE_BYTES);
    return s;
  endfunction

  localparam logic [20:0] RESET_SIZE = eff_size(21'(RESET_BUFFER));

endpackage

>>> rtl/ring_byte_fifo_allocator.sv
// Ring byte allocator: an input register, one pass of allocation logic, a result register.
// A beat passes from the input register to the result register, which drives out_valid.
// One beat per cycle while out_stall is low; the head/free-space update is registered as each beat advances.
// Under out_stall the input register takes one more beat, then in_stall rises.
// Synchronous active-low reset: head 0, free space 64 KiB, buffer size 64 KiB, pipeline empty.
// A cfg write reloads the size and reinitializes head and free space.
`include "ring_byte_fifo_allocator_macros.svh"

module ring_byte_fifo_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [20:0] in_byte_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_fragment_count,
  output logic [19:0] out_first_offset,
  output logic [20:0] out_first_length,
  output logic        out_second_offset,
  output logic [20:0] out_second_length,
  output logic [5:0]  out_align_padding,
  output logic [20:0] out_end_padding,
  output logic        out_fits,
  output logic        out_no_space_error,
  output logic [20:0] out_free_bytes
);

  logic                   s1_valid_r;
  logic [1:0]             s1_kind_r;
  logic [20:0]            s1_bytes_r;
  logic                   out_valid_r;
  rbfa_pkg::result_t      res_r, res_nxt;
  logic [20:0]            size_r;
  logic [19:0]            head_r, head_nxt;
  logic [20:0]            free_r, free_nxt;
  logic                   out_free;
  logic                   advance;

  logic [21:0] hb;
  logic [20:0] pad_end;
  logic [21:0] total;
  logic [22:0] nh;
  logic [21:0] second_len;
  logic [21:0] first_len;
  logic [21:0] nh_wrap;
  logic [21:0] aligned;
  logic [21:0] padding;
  logic [22:0] charge;
  logic [21:0] free_sum;
  logic        wrap;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_comb begin
    hb         = 22'(head_r) + 22'(s1_bytes_r);
    pad_end    = '0;
    if (s1_kind_r == rbfa_pkg::KIND_UNSPLIT && s1_bytes_r != '0 && hb >= 22'(size_r)) begin
      pad_end = size_r - 21'(head_r);
    end
    total      = 22'(s1_bytes_r) + 22'(pad_end);
    nh         = 23'(head_r) + 23'(total);
    wrap       = nh > 23'(size_r);
    second_len = wrap ? 22'(nh - 23'(size_r)) : '0;
    first_len  = total - second_len;
    nh_wrap    = wrap ? second_len : nh[21:0];
    aligned    = ((nh_wrap + 22'(rbfa_pkg::LINE_BYTES - 1)) >> rbfa_pkg::LINE_LOG2)
                 << rbfa_pkg::LINE_LOG2;
    padding    = aligned - nh_wrap;
    charge     = 23'(total) + 23'(padding);
    free_sum   = 22'(free_r) + 22'(s1_bytes_r);

    head_nxt = head_r;
    free_nxt = free_r;
    res_nxt  = '0;

    case (s1_kind_r)
      rbfa_pkg::KIND_ALLOC, rbfa_pkg::KIND_UNSPLIT: begin
        res_nxt.fits = 22'(free_r) > total;
        if (total != '0) begin
          if (22'(free_r) <= total) begin
            res_nxt.no_space_error = 1'b1;
          end else begin
            free_nxt = (23'(free_r) > charge) ? 21'(23'(free_r) - charge) : '0;
            head_nxt = (aligned >= 22'(size_r)) ? '0 : aligned[19:0];
            res_nxt.fragment_count = wrap ? 2'd2 : 2'd1;
            res_nxt.first_offset   = head_r;
            res_nxt.first_length   = first_len[20:0];
            res_nxt.second_length  = second_len[20:0];
            res_nxt.align_padding  = padding[5:0];
            res_nxt.end_padding    = pad_end;
          end
        end
      end
      rbfa_pkg::KIND_FREE: begin
        free_nxt = (free_sum > 22'(size_r)) ? size_r : free_sum[20:0];
      end
      default: begin
        res_nxt.fits = free_r > s1_bytes_r;
      end
    endcase
    res_nxt.free_bytes = free_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      size_r      <= rbfa_pkg::RESET_SIZE;
      head_r      <= '0;
      free_r      <= rbfa_pkg::RESET_SIZE;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (cfg_wr_en) begin
        size_r <= rbfa_pkg::eff_size(cfg_wr_data);
        head_r <= '0;
        free_r <= rbfa_pkg::eff_size(cfg_wr_data);
      end else if (advance) begin
        head_r <= head_nxt;
        free_r <= free_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind_r  <= in_kind;
      s1_bytes_r <= in_byte_count;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fragment_count = res_r.fragment_count;
  assign out_first_offset   = res_r.first_offset;
  assign out_first_length   = res_r.first_length;
  assign out_second_offset  = res_r.second_offset;
  assign out_second_length  = res_r.second_length;
  assign out_align_padding  = res_r.align_padding;
  assign out_end_padding    = res_r.end_padding;
  assign out_fits           = res_r.fits;
  assign out_no_space_error = res_r.no_space_error;
  assign out_free_bytes     = res_r.free_bytes;

  `RBFA_ASSERT_IMP(a_free_within_size, 1'b1, free_r <= size_r)
  `RBFA_ASSERT_IMP(a_head_aligned, 1'b1, head_r < size_r[19:0] || size_r[20])
  `RBFA_ASSERT_IMP(a_error_no_frag, out_valid_r && res_r.no_space_error,
                   res_r.fragment_count == 2'd0)
  `RBFA_ASSERT_IMP(a_wrap_has_tail, out_valid_r && res_r.fragment_count == 2'd2,
                   res_r.second_length != '0)
  `RBFA_ASSERT_NXT(a_stall_holds_s1, in_stall && !cfg_wr_en, s1_valid_r)

endmodule

>>> sim/tb_ring_byte_fifo_allocator.sv
// testbench for ring_byte_fifo_allocator: directed and random beats against a local model
module tb_ring_byte_fifo_allocator;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [20:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = rbfa_pkg::KIND_ALLOC;
  logic [20:0] in_byte_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_fragment_count;
  logic [19:0] out_first_offset;
  logic [20:0] out_first_length;
  logic        out_second_offset;
  logic [20:0] out_second_length;
  logic [5:0]  out_align_padding;
  logic [20:0] out_end_padding;
  logic        out_fits;
  logic        out_no_space_error;
  logic [20:0] out_free_bytes;

  ring_byte_fifo_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_byte_count(in_byte_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_fragment_count(out_fragment_count),
    .out_first_offset(out_first_offset),
    .out_first_length(out_first_length),
    .out_second_offset(out_second_offset),
    .out_second_length(out_second_length),
    .out_align_padding(out_align_padding),
    .out_end_padding(out_end_padding),
    .out_fits(out_fits),
    .out_no_space_error(out_no_space_error),
    .out_free_bytes(out_free_bytes)
  );

  // allocator model state
  logic [20:0] ring_cfg;
  int unsigned ring_head;
  int unsigned ring_free;

  rbfa_pkg::result_t expected_allocs[$];
  int mismatch_count = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;
  int hold_request = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_ring_byte_fifo_allocator: done, errors");
    $finish;
  end

  function automatic int unsigned ring_size(logic [20:0] req);
    int unsigned s;
    s = 32'(req);
    if (s > rbfa_pkg::SIZE_CAP) s = rbfa_pkg::SIZE_CAP;
    s = (s / rbfa_pkg::LINE_BYTES) * rbfa_pkg::LINE_BYTES;
    if (s < rbfa_pkg::LINE_BYTES) s = rbfa_pkg::LINE_BYTES;
    return s;
  endfunction

  function automatic rbfa_pkg::result_t compute_allocation(rbfa_pkg::kind_t k,
                                                           logic [20:0] n);
    int unsigned sz, h, pad_end, total, first_len, second_len, nfrag, nh;
    int unsigned aligned, padding, charge, sum;
    rbfa_pkg::result_t r;
    sz = ring_size(ring_cfg);
    h = ring_head;
    if (h >= sz) h = 0;
    if (ring_free > sz) ring_free = sz;
    r = '0;
    case (k)
      rbfa_pkg::KIND_ALLOC, rbfa_pkg::KIND_UNSPLIT: begin
        pad_end = 0;
        if (k == rbfa_pkg::KIND_UNSPLIT && n != 0 && h + n >= sz) pad_end = sz - h;
        total = n + pad_end;
        r.fits = ring_free > total;
        if (total != 0) begin
          if (ring_free <= total) begin
            r.no_space_error = 1'b1;
          end else begin
            first_len = total;
            second_len = 0;
            nfrag = 1;
            nh = h + total;
            if (nh > sz) begin
              second_len = nh - sz;
              first_len = total - second_len;
              nh = second_len;
              nfrag = 2;
            end
            aligned = ((nh + rbfa_pkg::LINE_BYTES - 1) / rbfa_pkg::LINE_BYTES)
                      * rbfa_pkg::LINE_BYTES;
            padding = aligned - nh;
            charge = total + padding;
            ring_free = (ring_free > charge) ? ring_free - charge : 0;
            r.fragment_count = 2'(nfrag);
            r.first_offset = 20'(h);
            r.first_length = 21'(first_len);
            r.second_length = 21'(second_len);
            r.align_padding = 6'(padding);
            r.end_padding = 21'(pad_end);
            h = (aligned >= sz) ? 0 : aligned;
          end
        end
      end
      rbfa_pkg::KIND_FREE: begin
        sum = ring_free + n;
        ring_free = (sum > sz) ? sz : sum;
      end
      default: r.fits = ring_free > n;
    endcase
    ring_head = h;
    r.free_bytes = 21'(ring_free);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [20:0] want, logic [20:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    rbfa_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_allocs.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatch_count++;
      end else begin
        want = expected_allocs.pop_front();
        compare_field("fragment_count", want.fragment_count, out_fragment_count);
        compare_field("first_offset", want.first_offset, out_first_offset);
        compare_field("first_length", want.first_length, out_first_length);
        compare_field("second_offset", want.second_offset, out_second_offset);
        compare_field("second_length", want.second_length, out_second_length);
        compare_field("align_padding", want.align_padding, out_align_padding);
        compare_field("end_padding", want.end_padding, out_end_padding);
        compare_field("fits", want.fits, out_fits);
        compare_field("no_space_error", want.no_space_error, out_no_space_error);
        compare_field("free_bytes", want.free_bytes, out_free_bytes);
      end
    end
  end

  // receiver stall pattern with optional long hold-off
  initial begin : receiver
    int hold_left;
    int mode_left;
    int stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(10, 80);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 20;
            3: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_beat(rbfa_pkg::kind_t k, int unsigned n);
    int gap;
    if (burst_left == 0) begin
      gap = (!sender_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= k;
    in_byte_count <= 21'(n);
    do @(posedge clk); while (in_stall);
    expected_allocs.push_back(compute_allocation(k, 21'(n)));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_allocs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(logic [20:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    ring_cfg = value;
    ring_head = 0;
    ring_free = ring_size(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly well-formed alloc/free/query traffic, some noise
  task automatic send_traffic_beat();
    int unsigned sz, roll;
    sz = ring_size(ring_cfg);
    roll = $urandom_range(0, 99);
    if (roll < 12)
      send_beat(rbfa_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 21'h1FFFFF));
    else if (roll < 18)
      send_beat(rbfa_pkg::kind_t'($urandom_range(0, 3)),
                $urandom_range(0, 2 * rbfa_pkg::LINE_BYTES));
    else if (ring_free < sz / 4 || roll < 30)
      send_beat(rbfa_pkg::KIND_FREE, $urandom_range(1, sz / 2));
    else if (roll < 38)
      send_beat(rbfa_pkg::KIND_QUERY, $urandom_range(0, sz));
    else if (roll < 46)
      send_beat(roll[0] ? rbfa_pkg::KIND_UNSPLIT : rbfa_pkg::KIND_ALLOC, sz - ring_head);
    else if (roll < 52)
      send_beat(rbfa_pkg::KIND_ALLOC, ring_free - (roll % 2));
    else
      send_beat(roll[0] ? rbfa_pkg::KIND_UNSPLIT : rbfa_pkg::KIND_ALLOC,
                $urandom_range(1, sz / 3 + 1));
  endtask

  task automatic test_reset_state();
    send_beat(rbfa_pkg::KIND_QUERY, 0);
    send_beat(rbfa_pkg::KIND_QUERY, 65536);
  endtask

  task automatic test_basic_allocs();
    send_beat(rbfa_pkg::KIND_ALLOC, 0);
    send_beat(rbfa_pkg::KIND_ALLOC, 1);
    send_beat(rbfa_pkg::KIND_UNSPLIT, 64);
    send_beat(rbfa_pkg::KIND_FREE, 21'h1FFFFF);
  endtask

  task automatic test_refusal_and_wrap();
    send_beat(rbfa_pkg::KIND_ALLOC, 65536);
    send_beat(rbfa_pkg::KIND_QUERY, 21'h1FFFFF);
    send_beat(rbfa_pkg::KIND_ALLOC, 65535);
    send_beat(rbfa_pkg::KIND_FREE, 65536);
  endtask

  task automatic test_padding_saturation();
    write_size(21'd0);
    send_beat(rbfa_pkg::KIND_ALLOC, 1);
    send_beat(rbfa_pkg::KIND_FREE, 20);
    send_beat(rbfa_pkg::KIND_ALLOC, 10);
    send_beat(rbfa_pkg::KIND_FREE, 64);
    send_beat(rbfa_pkg::KIND_UNSPLIT, 64);
  endtask

  task automatic test_unsplit_end();
    write_size(21'd1024);
    send_beat(rbfa_pkg::KIND_ALLOC, 700);
    send_beat(rbfa_pkg::KIND_FREE, 400);
    send_beat(rbfa_pkg::KIND_UNSPLIT, 400);
    send_beat(rbfa_pkg::KIND_FREE, 64);
    send_beat(rbfa_pkg::KIND_UNSPLIT, 400);
  endtask

  task automatic test_random_traffic(logic [20:0] cfg, int beats);
    write_size(cfg);
    repeat (beats) send_traffic_beat();
  endtask

  task automatic test_backpressure(int beats);
    write_size(21'd8192);
    sender_gaps = 1'b0;
    hold_request = 120;
    repeat (beats) send_traffic_beat();
    sender_gaps = 1'b1;
  endtask

  initial begin
    ring_cfg = 21'(rbfa_pkg::RESET_BUFFER);
    ring_head = 0;
    ring_free = ring_size(ring_cfg);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_basic_allocs();
    test_refusal_and_wrap();
    test_padding_saturation();
    test_unsplit_end();
    test_random_traffic(21'h1FFFFF, 120);
    test_random_traffic(21'd100000, 120);
    test_random_traffic(21'd63, 120);
    test_backpressure(70);
    test_random_traffic(21'd1000, 120);
    test_random_traffic(21'($urandom_range(0, 21'h1FFFFF)), 120);
    test_random_traffic(21'($urandom_range(64, 8192)), 120);
    test_random_traffic(21'd1048576, 120);
    test_random_traffic(21'($urandom_range(64, 4096)), 120);
    wait_drained();

    if (mismatch_count == 0)
      $display("tb_ring_byte_fifo_allocator: done, clean");
    else
      $display("tb_ring_byte_fifo_allocator: done, errors");
    $finish;
  end

endmodule
